[hw/rtl/flc_pkg.sv]
// ----------------------------------------------------------------------------
// flc_pkg
// shared widths and the term tag that travels from the sequencer to the mac
// ----------------------------------------------------------------------------
package flc_pkg;

  localparam int LEN_W    = 6;   // length registers and output index
  localparam int IN_IDX_W = 5;   // element index port
  localparam int SAMPLE_W = 16;  // q1.15 element
  localparam int PROD_W   = 32;  // q2.30 product
  localparam int ACC_W    = 37;  // q7.30 sum

  // tag carried alongside each multiply term
  typedef struct packed {
    logic             first;      // first term of an output sample
    logic             last_term;  // last term of an output sample
    logic             last_run;   // sample is the last of the run
    logic [LEN_W-1:0] n;          // output index
  } term_t;

endpackage

[hw/rtl/flc_store.sv]
// ----------------------------------------------------------------------------
// flc_store
// element store, one write port and one registered read port
// ----------------------------------------------------------------------------
module flc_store #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [ADDR_W-1:0]                     waddr,
  input  logic signed [flc_pkg::SAMPLE_W-1:0]   wdata,
  input  logic                                  re,
  input  logic [ADDR_W-1:0]                     raddr,
  output logic signed [flc_pkg::SAMPLE_W-1:0]   rdata
);

  logic signed [flc_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/flc_seq.sv]
// ----------------------------------------------------------------------------
// flc_seq
// walks output index n and term index k, one term a cycle while adv is high
// ----------------------------------------------------------------------------
module flc_seq #(
  parameter int MAX_LEN = 32,
  parameter int IDX_W   = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [flc_pkg::LEN_W-1:0]  signal_len,
  input  logic [flc_pkg::LEN_W-1:0]  kernel_len,
  input  logic                       adv,
  output logic                       idle,
  output logic                       issue,
  output flc_pkg::term_t             term,
  output logic [IDX_W-1:0]           sig_addr,
  output logic [IDX_W-1:0]           ker_addr
);

  localparam logic [flc_pkg::LEN_W-1:0] MaxLenV = flc_pkg::LEN_W'(MAX_LEN);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                    state;
  logic [flc_pkg::LEN_W-1:0] n, k, ls_m1, lk_m1, last_n;
  logic                      first;

  logic [flc_pkg::LEN_W-1:0] act_ls, act_lk, kmax, n1, kmin1, j;

  // clamp the configured lengths into 1..MAX_LEN
  always_comb begin
    priority if (signal_len == '0) act_ls = flc_pkg::LEN_W'(1);
    else if (signal_len > MaxLenV) act_ls = MaxLenV;
    else                           act_ls = signal_len;
    priority if (kernel_len == '0) act_lk = flc_pkg::LEN_W'(1);
    else if (kernel_len > MaxLenV) act_lk = MaxLenV;
    else                           act_lk = kernel_len;
  end

  assign kmax  = (n < ls_m1) ? n : ls_m1;
  assign n1    = n + flc_pkg::LEN_W'(1);
  assign kmin1 = (n1 >= lk_m1) ? n1 - lk_m1 : '0;
  assign j     = n - k;

  assign idle     = (state == ST_IDLE);
  assign issue    = (state == ST_RUN) && adv;
  assign sig_addr = k[IDX_W-1:0];
  assign ker_addr = j[IDX_W-1:0];

  assign term.first     = first;
  assign term.last_term = (k == kmax);
  assign term.last_run  = (n == last_n);
  assign term.n         = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue && term.last_term && term.last_run) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (idle && start) begin
      ls_m1  <= act_ls - flc_pkg::LEN_W'(1);
      lk_m1  <= act_lk - flc_pkg::LEN_W'(1);
      last_n <= act_ls + act_lk - flc_pkg::LEN_W'(2);
      n      <= '0;
      k      <= '0;
      first  <= 1'b1;
    end else if (issue) begin
      if (term.last_term) begin
        n     <= n1;
        k     <= kmin1;
        first <= 1'b1;
      end else begin
        k     <= k + flc_pkg::LEN_W'(1);
        first <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> k <= kmax)
    else $error("term index beyond upper bound");

  a_j_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> j <= lk_m1)
    else $error("kernel index beyond kernel length");

  a_n_steps: assert property (@(posedge clk) disable iff (rst)
    (issue && term.last_term && !term.last_run) |=> n == $past(n) + flc_pkg::LEN_W'(1))
    else $error("output index did not step after last term");
`endif

endmodule

[hw/rtl/flc_mac.sv]
// ----------------------------------------------------------------------------
// flc_mac
// shared multiply-accumulate pipeline and output register
// ----------------------------------------------------------------------------
module flc_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 issue,
  input  flc_pkg::term_t                       term_in,
  input  logic signed [flc_pkg::SAMPLE_W-1:0]  s_data,
  input  logic signed [flc_pkg::SAMPLE_W-1:0]  h_data,
  output logic                                 adv,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [flc_pkg::ACC_W-1:0]     result_value,
  output logic [flc_pkg::LEN_W-1:0]            result_index,
  output logic                                 last_of_run
);

  logic                                s1_valid, s2_valid;
  flc_pkg::term_t                      s1_term, s2_term;
  logic signed [flc_pkg::PROD_W-1:0]   prod;
  logic signed [flc_pkg::ACC_W-1:0]    acc, acc_next;

  // whole pipe moves only when the output register can take a word
  assign adv = !out_valid || out_ready;

  assign acc_next = (s2_term.first ? '0 : acc) +
    {{(flc_pkg::ACC_W-flc_pkg::PROD_W){prod[flc_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_term.last_term;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_term <= term_in;
      s2_term <= s1_term;
      prod    <= s_data * h_data;
      if (s2_valid) begin
        acc <= acc_next;
      end
      if (s2_valid && s2_term.last_term) begin
        result_value <= acc_next;
        result_index <= s2_term.n;
        last_of_run  <= s2_term.last_run;
      end
    end
  end

endmodule

[hw/rtl/full_linear_convolution_core.sv]
// ----------------------------------------------------------------------------
// full_linear_convolution_core
// full linear convolution of a q1.15 signal with a q1.15 kernel, exact q7.30
// sums from one shared multiply-accumulate unit
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    mode, element_index, sample_value
//  out      source     out_valid / out_ready  result_value, result_index,
//                                             last_of_run
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  a compute word issues one product a cycle while the output is not stalled,
//  clamped signal_len * kernel_len products in all (at most MAX_LEN squared),
//  and the last term of each sample passes the read, product and output registers
//  in_ready is low while the sequencer walks the terms
//  a stalled output word freezes the whole mac pipe until it is taken
//  reset clears control and sets both lengths to one; stores are not cleared
// ----------------------------------------------------------------------------
module full_linear_convolution_core #(
  parameter int MAX_LEN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // item channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic [flc_pkg::IN_IDX_W-1:0]         element_index,
  input  logic signed [flc_pkg::SAMPLE_W-1:0]  sample_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [flc_pkg::ACC_W-1:0]     result_value,
  output logic [flc_pkg::LEN_W-1:0]            result_index,
  output logic                                 last_of_run,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [flc_pkg::LEN_W-1:0]            cfg_data
);

  localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [flc_pkg::LEN_W-1:0] MaxLenV = flc_pkg::LEN_W'(MAX_LEN);

  // item modes
  localparam logic [1:0] MODE_LOAD_SIG = 2'd0;
  localparam logic [1:0] MODE_LOAD_KER = 2'd1;
  localparam logic [1:0] MODE_COMPUTE  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_SIGNAL_LEN = 2'd0;
  localparam logic [1:0] CFG_KERNEL_LEN = 2'd1;

  logic [flc_pkg::LEN_W-1:0] signal_len, kernel_len;

  logic in_acc, idx_ok, sig_we, ker_we, start;
  logic adv, issue, idle;
  flc_pkg::term_t term;
  logic [IDX_W-1:0] sig_addr, ker_addr;
  logic signed [flc_pkg::SAMPLE_W-1:0] s_data, h_data;

  // config is always taken; out of range indexes fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_len <= flc_pkg::LEN_W'(1);
      kernel_len <= flc_pkg::LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SIGNAL_LEN) begin
        signal_len <= cfg_data;
      end
      if (cfg_index == CFG_KERNEL_LEN) begin
        kernel_len <= cfg_data;
      end
    end
  end

  // item decode: loads write the stores, compute kicks the sequencer
  assign in_ready = idle;
  assign in_acc   = in_valid && in_ready;
  assign idx_ok   = {1'b0, element_index} < MaxLenV;
  assign sig_we   = in_acc && (mode == MODE_LOAD_SIG) && idx_ok;
  assign ker_we   = in_acc && (mode == MODE_LOAD_KER) && idx_ok;
  assign start    = in_acc && (mode == MODE_COMPUTE);

  flc_store #(.DEPTH(MAX_LEN), .ADDR_W(IDX_W)) u_sig_store (
    .clk   (clk),
    .we    (sig_we),
    .waddr (element_index[IDX_W-1:0]),
    .wdata (sample_value),
    .re    (adv),
    .raddr (sig_addr),
    .rdata (s_data)
  );

  flc_store #(.DEPTH(MAX_LEN), .ADDR_W(IDX_W)) u_ker_store (
    .clk   (clk),
    .we    (ker_we),
    .waddr (element_index[IDX_W-1:0]),
    .wdata (sample_value),
    .re    (adv),
    .raddr (ker_addr),
    .rdata (h_data)
  );

  // term sequencer: one (n, k) pair per advancing cycle
  flc_seq #(.MAX_LEN(MAX_LEN), .IDX_W(IDX_W)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .signal_len (signal_len),
    .kernel_len (kernel_len),
    .adv        (adv),
    .idle       (idle),
    .issue      (issue),
    .term       (term),
    .sig_addr   (sig_addr),
    .ker_addr   (ker_addr)
  );

  // shared mac with output word register
  flc_mac u_mac (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .term_in      (term),
    .s_data       (s_data),
    .h_data       (h_data),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_index (result_index),
    .last_of_run  (last_of_run)
  );

endmodule

[dv/flc_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flc_tb_pkg
// word codes, register indexes and the expected sample record shared by the
// convolution testbench and its checker
// ----------------------------------------------------------------------------
package flc_tb_pkg;

  localparam int MAX_LEN = 32;

  typedef enum logic [1:0] {
    MODE_LOAD_SIGNAL = 2'd0,
    MODE_LOAD_KERNEL = 2'd1,
    MODE_CONVOLVE    = 2'd2,
    MODE_UNUSED      = 2'd3
  } flc_mode_e;

  typedef enum logic [1:0] {
    REG_SIGNAL_LEN = 2'd0,
    REG_KERNEL_LEN = 2'd1,
    REG_SPARE_2    = 2'd2,
    REG_SPARE_3    = 2'd3
  } flc_reg_e;

  // one output sample as the block should present it
  typedef struct packed {
    logic [flc_pkg::ACC_W-1:0] value;
    logic [flc_pkg::LEN_W-1:0] index;
    logic                      last;
  } conv_sample_t;

  // zero counts as one, anything past the store depth as the full depth
  function automatic int effective_len(input logic [flc_pkg::LEN_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_LEN) return MAX_LEN;
    return int'(raw);
  endfunction

endpackage

[dv/flc_conv_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flc_conv_checker
// watches the item, result and register channels of the convolution core,
// keeps its own stores and lengths, predicts every output sample of a
// convolve word and compares the results in order
// ----------------------------------------------------------------------------
module flc_conv_checker
  import flc_pkg::*;
  import flc_tb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic [IN_IDX_W-1:0]        element_index,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [ACC_W-1:0]    result_value,
  input  logic [LEN_W-1:0]           result_index,
  input  logic                       last_of_run,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [LEN_W-1:0]           cfg_data,
  output int                         fail_count,
  output int                         samples_outstanding
);

  logic signed [SAMPLE_W-1:0] signal_mem [MAX_LEN];
  logic signed [SAMPLE_W-1:0] kernel_mem [MAX_LEN];
  logic [LEN_W-1:0]           signal_len_reg;
  logic [LEN_W-1:0]           kernel_len_reg;
  conv_sample_t               expected_samples [$];

  // exact q7.30 sums over every overlapping pair
  function automatic void predict_convolution();
    int                        sig_n;
    int                        ker_n;
    int                        total;
    int                        k_lo;
    int                        k_hi;
    logic signed [ACC_W-1:0]   acc;
    logic signed [PROD_W-1:0]  prod;
    conv_sample_t              entry;
    sig_n = effective_len(signal_len_reg);
    ker_n = effective_len(kernel_len_reg);
    total = sig_n + ker_n - 1;
    for (int n = 0; n < total; n++) begin
      acc  = '0;
      k_lo = (n >= ker_n - 1) ? n - (ker_n - 1) : 0;
      k_hi = (n < sig_n - 1) ? n : sig_n - 1;
      for (int k = k_lo; k <= k_hi; k++) begin
        prod = signal_mem[k] * kernel_mem[n - k];
        acc  = acc + prod;
      end
      entry.value = acc;
      entry.index = LEN_W'(n);
      entry.last  = (n == total - 1);
      expected_samples.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    conv_sample_t want;
    if (rst) begin
      expected_samples.delete();
      signal_len_reg = LEN_W'(1);
      kernel_len_reg = LEN_W'(1);
      for (int i = 0; i < MAX_LEN; i++) begin
        signal_mem[i] = '0;
        kernel_mem[i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIGNAL_LEN) signal_len_reg = cfg_data;
        else if (cfg_index == REG_KERNEL_LEN) kernel_len_reg = cfg_data;
      end

      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: result word with none expected: value %0d index %0d last %0b",
                   $time, result_value, result_index, last_of_run);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (result_value !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d (index %0d)",
                     $time, $signed(want.value), result_value, want.index);
            fail_count++;
          end
          if (result_index !== want.index) begin
            $display("%0t: result_index expected %0d actual %0d",
                     $time, want.index, result_index);
            fail_count++;
          end
          if (last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b (index %0d)",
                     $time, want.last, last_of_run, want.index);
            fail_count++;
          end
        end
      end

      if (in_valid && in_ready) begin
        case (mode)
          MODE_LOAD_SIGNAL: signal_mem[element_index] = sample_value;
          MODE_LOAD_KERNEL: kernel_mem[element_index] = sample_value;
          MODE_CONVOLVE:    predict_convolution();
          default: ;
        endcase
      end
    end
    samples_outstanding = expected_samples.size();
  end

endmodule

[dv/full_linear_convolution_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// full_linear_convolution_core_tb
// drives load, convolve and ignored words plus length writes into the core,
// with random gaps and stalls on both channels, one long result hold-off and
// a full drain before each length change; the checker predicts and compares,
// this module gives the verdict
// ----------------------------------------------------------------------------
module full_linear_convolution_core_tb;
  import flc_pkg::*;
  import flc_tb_pkg::*;

  localparam int ITEM_TARGET   = 300;
  localparam int DRAIN_PAUSE   = 8;     // pause after the last expected sample is taken
  localparam int RX_HOLD_CYCLES = 400;  // long result hold-off
  localparam int QUIET_LIMIT   = 6000;  // cycles with no handshake anywhere

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 mode = MODE_LOAD_SIGNAL;
  logic [IN_IDX_W-1:0]        element_index = '0;
  logic signed [SAMPLE_W-1:0] sample_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [ACC_W-1:0]    result_value;
  logic [LEN_W-1:0]           result_index;
  logic                       last_of_run;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [1:0]                 cfg_index = REG_SIGNAL_LEN;
  logic [LEN_W-1:0]           cfg_data = '0;

  int fail_count;
  int samples_outstanding;

  // stimulus bookkeeping
  logic [MAX_LEN-1:0] signal_written = '0;
  logic [MAX_LEN-1:0] kernel_written = '0;
  int                 items_sent = 0;
  int                 quiet_cycles = 0;
  bit                 calm = 1'b0;          // no gaps on either side while set
  bit                 hold_request = 1'b0;  // asks the receiver for a long hold-off

  always #5 clk = ~clk;

  full_linear_convolution_core uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .element_index (element_index),
    .sample_value  (sample_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_value  (result_value),
    .result_index  (result_index),
    .last_of_run   (last_of_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  flc_conv_checker chk (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .mode                (mode),
    .element_index       (element_index),
    .sample_value        (sample_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .result_value        (result_value),
    .result_index        (result_index),
    .last_of_run         (last_of_run),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .samples_outstanding (samples_outstanding)
  );

  // watchdog: any handshake, or reset, restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off when asked for
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (int c = 0; c < RX_HOLD_CYCLES; c++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one item word; gaps only ever lower valid before a new word is raised
  task automatic send_word(input flc_mode_e m, input logic [IN_IDX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val);
    if (!calm) begin
      while ($urandom_range(0, 99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    mode          <= m;
    element_index <= idx;
    sample_value  <= val;
    do @(posedge clk); while (!in_ready);
    if (m == MODE_LOAD_SIGNAL) signal_written[idx] = 1'b1;
    if (m == MODE_LOAD_KERNEL) kernel_written[idx] = 1'b1;
    if (m != MODE_UNUSED) items_sent++;
  endtask

  // one register write; caller lowers cfg_valid after its last write
  task automatic write_reg(input flc_reg_e r, input logic [LEN_W-1:0] d);
    if (!calm) begin
      while ($urandom_range(0, 99) < 20) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
    end
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop offering words, wait for every expected sample, then let the
  // tail of any load settle before the registers may change
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // mostly random q1.15, now and then one of the corner values
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly small lengths so the run stays short, with zero and oversize too
  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEN_W'($urandom_range(32, 63));
      2:       return LEN_W'($urandom_range(0, 63));
      default: return LEN_W'($urandom_range(1, 8));
    endcase
  endfunction

  // set both lengths, then a few load / convolve runs on that setting;
  // every element in use is written before a convolve word goes out
  task automatic convolve_phase(input logic [LEN_W-1:0] sig_reg,
                                input logic [LEN_W-1:0] ker_reg,
                                input int runs, input bit all_negative);
    int sig_n;
    int ker_n;
    int loads;
    drain();
    write_reg(REG_SIGNAL_LEN, sig_reg);
    write_reg(REG_KERNEL_LEN, ker_reg);
    if ($urandom_range(0, 7) == 0) begin
      write_reg(flc_reg_e'($urandom_range(2, 3)), LEN_W'($urandom_range(0, 63)));
    end
    cfg_valid <= 1'b0;
    sig_n = effective_len(sig_reg);
    ker_n = effective_len(ker_reg);
    for (int r = 0; r < runs; r++) begin
      loads = $urandom_range(0, 5);
      for (int l = 0; l < loads; l++) begin
        case ($urandom_range(0, 7))
          0: send_word(MODE_UNUSED, IN_IDX_W'($urandom_range(0, 31)), pick_sample());
          1: send_word(MODE_LOAD_SIGNAL, IN_IDX_W'($urandom_range(0, 31)), pick_sample());
          2: send_word(MODE_LOAD_KERNEL, IN_IDX_W'($urandom_range(0, 31)), pick_sample());
          3, 4: send_word(MODE_LOAD_SIGNAL, IN_IDX_W'($urandom_range(0, sig_n - 1)),
                          pick_sample());
          default: send_word(MODE_LOAD_KERNEL, IN_IDX_W'($urandom_range(0, ker_n - 1)),
                             pick_sample());
        endcase
      end
      // fill the gaps; the all-negative case rewrites everything in use
      for (int i = 0; i < sig_n; i++) begin
        if (all_negative) send_word(MODE_LOAD_SIGNAL, IN_IDX_W'(i), 16'h8000);
        else if (!signal_written[i]) send_word(MODE_LOAD_SIGNAL, IN_IDX_W'(i), pick_sample());
      end
      for (int i = 0; i < ker_n; i++) begin
        if (all_negative) send_word(MODE_LOAD_KERNEL, IN_IDX_W'(i), 16'h8000);
        else if (!kernel_written[i]) send_word(MODE_LOAD_KERNEL, IN_IDX_W'(i), pick_sample());
      end
      send_word(MODE_CONVOLVE, IN_IDX_W'($urandom_range(0, 31)), pick_sample());
    end
  endtask

  initial begin
    int phase_no;
    phase_no = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // lengths are one after reset: most negative squared, then mixed signs
    send_word(MODE_LOAD_SIGNAL, 5'd0, 16'h8000);
    send_word(MODE_LOAD_KERNEL, 5'd0, 16'h8000);
    send_word(MODE_CONVOLVE, 5'd0, 16'h0000);
    // unused mode word must leave no trace
    send_word(MODE_UNUSED, 5'd31, 16'h7fff);
    send_word(MODE_LOAD_KERNEL, 5'd0, 16'h7fff);
    // index and value of a convolve word are don't-care
    send_word(MODE_CONVOLVE, 5'd31, 16'h8000);

    // spare register indexes do nothing; a zero length behaves as one
    drain();
    write_reg(REG_SPARE_2, 6'h3f);
    write_reg(REG_SPARE_3, 6'h2a);
    write_reg(REG_SIGNAL_LEN, 6'd0);
    write_reg(REG_KERNEL_LEN, 6'd3);
    cfg_valid <= 1'b0;
    send_word(MODE_LOAD_KERNEL, 5'd1, 16'h7fff);
    send_word(MODE_LOAD_KERNEL, 5'd2, 16'hffff);
    send_word(MODE_CONVOLVE, 5'd7, 16'h1234);

    // length extremes: oversize signal with full kernel, largest possible sums,
    // then a two element signal against the deepest kernel
    convolve_phase(6'd63, 6'd32, 1, 1'b1);
    convolve_phase(6'd2, 6'd63, 1, 1'b0);
    convolve_phase(6'd1, 6'd1, 1, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      phase_no++;
      calm = (phase_no >= 6 && phase_no <= 10);
      if (phase_no == 3) begin
        // block fills behind a held result channel and backs up the input
        drain();
        hold_request = 1'b1;
        convolve_phase(6'd4, 6'd4, 3, 1'b0);
      end else if (phase_no == 14) begin
        convolve_phase(6'd32, 6'd1, 1, 1'b0);
      end else begin
        convolve_phase(pick_len(), pick_len(), $urandom_range(1, 3), 1'b0);
      end
    end

    drain();
    if (fail_count == 0 && samples_outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[full_linear_convolution_core.f]
hw/rtl/flc_pkg.sv
hw/rtl/flc_store.sv
hw/rtl/flc_seq.sv
hw/rtl/flc_mac.sv
hw/rtl/full_linear_convolution_core.sv
dv/flc_tb_pkg.sv
dv/flc_conv_checker.sv
dv/full_linear_convolution_core_tb.sv
